>>> hdl/pdl_pkg.sv
package pdl_pkg;

   localparam int CH_W         = 2;
   localparam int TIME_W       = 32;
   localparam int LEVEL_W      = 12;
   localparam int DIGIT_W      = 4;
   localparam int SEG_W        = 7;
   localparam int SHIFT_W      = 16;
   localparam int NUM_CHANNELS = 3;

   localparam int NUM_SWITCHES_DEF = 3;

   // elapsed times below MS_FULL fit these bits and are scaled, anything else saturates
   localparam int ELAPSED_W = 10;
   localparam int PROD_W    = ELAPSED_W + LEVEL_W;

   localparam logic [LEVEL_W-1:0]  LEVEL_MAX = 12'd4095;
   localparam logic [TIME_W-1:0]   MS_FULL   = 32'd1000;
   // floor(2^22 / 1000): quotient estimate is low by at most one
   localparam int                  RECIP_SHIFT = 22;
   localparam logic [12:0]         RECIP       = 13'd4194;

   typedef enum logic [CH_W-1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2
   } channel_type;

   typedef struct packed {
      logic [CH_W-1:0]   switch_id;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]    channel;
      logic [LEVEL_W-1:0] red_level;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] blue_level;
      logic [DIGIT_W-1:0] tens_digit;
      logic [DIGIT_W-1:0] ones_digit;
      logic [SEG_W-1:0]   tens_segments;
      logic [SEG_W-1:0]   ones_segments;
      logic [SHIFT_W-1:0] shift_word;
   } rsp_type;

   // release measured: channel, saturation flag and low elapsed bits
   typedef struct packed {
      logic [CH_W-1:0]      channel;
      logic                 sat;
      logic [ELAPSED_W-1:0] elapsed;
   } elapsed_type;

   typedef struct packed {
      logic [CH_W-1:0]    channel;
      logic               sat;
      logic [PROD_W-1:0]  prod;
      logic [LEVEL_W-1:0] quot;
   } quot_type;

   typedef struct packed {
      logic [CH_W-1:0]    channel;
      logic [LEVEL_W-1:0] level;
   } level_type;

   function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      unique case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h27;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h67;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

endpackage

>>> hdl/pdl_track.sv
module pdl_track
   import pdl_pkg::*;
#(
   parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        out_valid,
   input  logic        out_stall,
   output elapsed_type out_data
);

   localparam int SLOT_COUNT =
      (NUM_SWITCHES < NUM_CHANNELS) ? NUM_SWITCHES : NUM_CHANNELS;

   logic [SLOT_COUNT-1:0] held_ff, held_in;
   logic [TIME_W-1:0]     start_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] hit;
   logic [TIME_W-1:0]     start_sel;
   logic [TIME_W-1:0]     elapsed;
   logic                  accept, is_release;
   logic                  valid_ff, valid_in;
   elapsed_type           data_ff;

   assign req_stall = valid_ff && out_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      start_sel = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         hit[i] = (req_data.switch_id == CH_W'(i));
         if (hit[i]) begin
            start_sel = start_sel | start_ff[i];
         end
      end
   end

   assign is_release = accept && |(hit & held_ff);
   assign elapsed    = req_data.now_ms - start_sel;

   always_comb begin
      held_in = held_ff;
      if (accept) begin
         held_in = held_ff ^ hit;
      end
   end

   assign valid_in = (valid_ff && out_stall) ? 1'b1 : is_release;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         held_ff  <= held_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (accept && hit[i] && !held_ff[i]) begin
            start_ff[i] <= req_data.now_ms;
         end
      end
      if (is_release) begin
         data_ff.channel <= req_data.switch_id;
         data_ff.sat     <= (elapsed >= MS_FULL);
         data_ff.elapsed <= elapsed[ELAPSED_W-1:0];
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hdl/pdl_scale.sv
module pdl_scale
   import pdl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_stall,
   input  elapsed_type in_data,
   output logic        out_valid,
   input  logic        out_stall,
   output level_type   out_data
);

   localparam int MUL_W = PROD_W + 13;

   logic              q_valid_ff, q_valid_in;
   quot_type          q_ff;
   logic              q_stall;
   logic [PROD_W-1:0] prod;
   logic [MUL_W-1:0]  recip_prod;

   logic              l_valid_ff, l_valid_in;
   level_type         l_ff;
   logic [PROD_W-1:0] back;
   logic [PROD_W-1:0] rem;
   logic [LEVEL_W-1:0] level;

   // e * 4095 = (e << 12) - e
   assign prod       = {in_data.elapsed, {LEVEL_W{1'b0}}} - PROD_W'(in_data.elapsed);
   assign recip_prod = MUL_W'(prod) * MUL_W'(RECIP);

   assign in_stall   = q_valid_ff && q_stall;
   assign q_valid_in = in_stall ? 1'b1 : in_valid;

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         q_ff.channel <= in_data.channel;
         q_ff.sat     <= in_data.sat;
         q_ff.prod    <= prod;
         q_ff.quot    <= recip_prod[RECIP_SHIFT +: LEVEL_W];
      end
   end

   // remainder check lifts the low estimate by one where needed
   assign back  = PROD_W'(q_ff.quot) * PROD_W'(MS_FULL);
   assign rem   = q_ff.prod - back;
   always_comb begin
      if (q_ff.sat) begin
         level = LEVEL_MAX;
      end else if (rem >= PROD_W'(MS_FULL)) begin
         level = q_ff.quot + LEVEL_W'(1);
      end else begin
         level = q_ff.quot;
      end
   end

   assign q_stall    = l_valid_ff && out_stall;
   assign l_valid_in = q_stall ? 1'b1 : q_valid_ff;

   always_ff @(posedge clock) begin
      if (!q_stall && q_valid_ff) begin
         l_ff.channel <= q_ff.channel;
         l_ff.level   <= level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
         l_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= q_valid_in;
         l_valid_ff <= l_valid_in;
      end
   end

   assign out_valid = l_valid_ff;
   assign out_data  = l_ff;

endmodule

>>> hdl/pdl_digits.sv
module pdl_digits
   import pdl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_stall,
   input  level_type in_data,
   output logic      out_valid,
   input  logic      out_stall,
   output rsp_type   out_data
);

   logic               valid_ff, valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [15:0]        times10;
   logic [18:0]        times100;
   logic [DIGIT_W-1:0] tens;
   logic [6:0]         hundredths;
   logic [6:0]         tens_x10;
   logic [SEG_W-1:0]   tseg, oseg;

   assign times10    = 16'(in_data.level) * 16'd10;
   assign times100   = 19'(in_data.level) * 19'd100;
   assign tens       = times10[15:12];
   assign hundredths = times100[18:12];
   // floor(100v/4096) mod 10 equals floor(100v/4096) - 10*floor(10v/4096)
   assign tens_x10   = 7'(tens) * 7'd10;
   assign tseg       = seg_of(tens);

   always_comb begin
      rsp_in.channel       = in_data.channel;
      rsp_in.red_level     = (in_data.channel == CH_RED)   ? in_data.level : '0;
      rsp_in.green_level   = (in_data.channel == CH_GREEN) ? in_data.level : '0;
      rsp_in.blue_level    = (in_data.channel == CH_BLUE)  ? in_data.level : '0;
      rsp_in.tens_digit    = tens;
      rsp_in.ones_digit    = DIGIT_W'(hundredths - tens_x10);
      oseg                 = seg_of(rsp_in.ones_digit);
      rsp_in.tens_segments = tseg;
      rsp_in.ones_segments = oseg;
      rsp_in.shift_word    = {1'b0, oseg, 1'b0, tseg};
   end

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? 1'b1 : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

>>> hdl/press_duration_to_led_level.sv
// A release request passes through the tracking, quotient, level and output registers
//   in that order before its response shows.
// Throughput: one request per cycle while req_stall is low; press requests give no response.
// A stalled response backs up through full stages only; intake stalls once all four hold data.
// Reset (synchronous, active high) clears the held flags and all valid bits;
//   press time stamps are not cleared.
module press_duration_to_led_level
   import pdl_pkg::*;
#(
   parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic        e_valid, e_stall;
   elapsed_type e_data;
   logic        l_valid, l_stall;
   level_type   l_data;

   pdl_track #(
      .NUM_SWITCHES(NUM_SWITCHES)
   ) u_track (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .out_valid(e_valid),
      .out_stall(e_stall),
      .out_data (e_data)
   );

   pdl_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .in_valid (e_valid),
      .in_stall (e_stall),
      .in_data  (e_data),
      .out_valid(l_valid),
      .out_stall(l_stall),
      .out_data (l_data)
   );

   pdl_digits u_digits (
      .clock    (clock),
      .reset    (reset),
      .in_valid (l_valid),
      .in_stall (l_stall),
      .in_data  (l_data),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_data (rsp_data)
   );

endmodule

>>> hdl/pdl_checker.sv
module pdl_checker
   import pdl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.channel == CH_RED   || rsp_data.red_level   == '0) &&
         (rsp_data.channel == CH_GREEN || rsp_data.green_level == '0) &&
         (rsp_data.channel == CH_BLUE  || rsp_data.blue_level  == '0) &&
         (rsp_data.channel == CH_RED || rsp_data.channel == CH_GREEN ||
          rsp_data.channel == CH_BLUE))
      else $error("level on a channel that was not set");

   a_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.tens_digit <= 4'd9 && rsp_data.ones_digit <= 4'd9 &&
         rsp_data.tens_segments == seg_of(rsp_data.tens_digit) &&
         rsp_data.ones_segments == seg_of(rsp_data.ones_digit))
      else $error("digit or segment pattern out of range");

   a_shift_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.shift_word ==
         {1'b0, rsp_data.ones_segments, 1'b0, rsp_data.tens_segments})
      else $error("shift word does not match segments");

endmodule

bind press_duration_to_led_level pdl_checker u_pdl_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
